// ----- src/cfsd_pkg.sv -----
// shared types, constants and a helper function of the command frame decoder
`default_nettype none

package cfsd_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int MASK_W     = 8;
    localparam int UNIT_W     = 3;
    localparam int SECTOR_W   = 16;
    localparam int LEN_W      = 9;
    localparam int REG_IDX_W  = 2;

    // window
    localparam int WINDOW_DEPTH = 4;
    localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    localparam int DRIVE_COUNT_DEFAULT = 8;

    // device ids
    localparam logic [BYTE_W-1:0] ID_DISK_FIRST = 8'h31;
    localparam logic [BYTE_W-1:0] ID_DISK_LAST  = 8'h38;
    localparam logic [BYTE_W-1:0] ID_PRN_FIRST  = 8'h40;
    localparam logic [BYTE_W-1:0] ID_PRN_UNIT0  = 8'h41;
    localparam logic [BYTE_W-1:0] ID_PRN_LAST   = 8'h48;
    localparam logic [BYTE_W-1:0] ID_SER_FIRST  = 8'h50;
    localparam logic [BYTE_W-1:0] ID_SER_LAST   = 8'h53;

    // commands
    localparam logic [BYTE_W-1:0] CMD_READ   = 8'h52;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h57;
    localparam logic [BYTE_W-1:0] CMD_PUT    = 8'h50;
    localparam logic [BYTE_W-1:0] CMD_STATUS = 8'h53;

    // drive status
    localparam logic [BYTE_W-1:0] STAT_SINGLE = 8'h10;
    localparam logic [BYTE_W-1:0] STAT_LARGE  = 8'h60;
    localparam logic [BYTE_W-1:0] STAT_ENH    = 8'h80;
    localparam logic [BYTE_W-1:0] STAT_RO_BIT = 8'h08;

    // transfer lengths
    localparam logic [LEN_W-1:0]    LEN_SMALL     = 9'd128;
    localparam logic [LEN_W-1:0]    LEN_LARGE     = 9'd256;
    localparam logic [LEN_W-1:0]    LEN_STATUS    = 9'd4;
    localparam logic [SECTOR_W-1:0] SEC_BOOT_LAST = 16'd3;

    typedef logic [MASK_W-1:0] t_mask;

    typedef enum logic [1:0] {
        KIND_DISK    = 2'd0,
        KIND_PRINTER = 2'd1,
        KIND_SERIAL  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_IGNORED      = 3'd0,
        ACT_NO_IMAGE     = 3'd1,
        ACT_UNSUPPORTED  = 3'd2,
        ACT_READ         = 3'd3,
        ACT_WRITE_OK     = 3'd4,
        ACT_WRITE_REFUSE = 3'd5,
        ACT_STATUS       = 3'd6,
        ACT_NO_REPLY     = 3'd7
    } t_action;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PRESENT  = 2'd0,
        REG_READONLY = 2'd1,
        REG_LARGE    = 2'd2,
        REG_ENHANCED = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [BYTE_W-1:0]   id;
        logic [BYTE_W-1:0]   cmd;
        logic [SECTOR_W-1:0] sector;
    } t_frame;

    typedef struct packed {
        t_mask present;
        t_mask readonly;
        t_mask large_sec;
        t_mask enhanced;
    } t_masks;

    typedef struct packed {
        logic [1:0]          device_kind;
        logic [UNIT_W-1:0]   unit;
        logic [BYTE_W-1:0]   command_code;
        logic [SECTOR_W-1:0] sector;
        logic [2:0]          action;
        logic [LEN_W-1:0]    data_length;
        logic [BYTE_W-1:0]   status_byte;
        logic [BYTE_W-1:0]   status_checksum;
    } t_result;

    // 8-bit add with end-around carry
    function automatic logic [BYTE_W-1:0] fold_add(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

endpackage

`default_nettype wire

// ----- src/cfsd_if.sv -----
// channel interfaces: bus bytes in, decoded frames out, register writes
`default_nettype none

interface cfsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_byte;

    modport source(output valid, output bus_byte, input ready);
    modport sink(input valid, input bus_byte, output ready);
endinterface

interface cfsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  device_kind;
    logic [2:0]  unit;
    logic [7:0]  command_code;
    logic [15:0] sector;
    logic [2:0]  action;
    logic [8:0]  data_length;
    logic [7:0]  status_byte;
    logic [7:0]  status_checksum;

    modport source(output valid, output device_kind, output unit, output command_code,
                   output sector, output action, output data_length,
                   output status_byte, output status_checksum, input ready);
    modport sink(input valid, input device_kind, input unit, input command_code,
                 input sector, input action, input data_length,
                 input status_byte, input status_checksum, output ready);
endinterface

interface cfsd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wdata;

    modport source(output valid, output reg_index, output wdata, input ready);
    modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- src/cfsd_window.sv -----
// sliding four-byte window with checksum match against the incoming byte
`default_nettype none

module cfsd_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [cfsd_pkg::BYTE_W-1:0] i_byte,
    output logic                             o_match,
    output cfsd_pkg::t_frame                 o_frame
);

    logic [cfsd_pkg::BYTE_W-1:0] r_win [cfsd_pkg::WINDOW_DEPTH];
    logic [cfsd_pkg::FILL_W-1:0] r_fill;
    logic [cfsd_pkg::BYTE_W-1:0] sum;
    logic                        full;

    assign full = (r_fill == cfsd_pkg::FILL_W'(cfsd_pkg::WINDOW_DEPTH));

    always_comb begin
        sum = '0;
        for (int k = 0; k < cfsd_pkg::WINDOW_DEPTH; k++) begin
            sum = cfsd_pkg::fold_add(sum, r_win[k]);
        end
    end

    assign o_match = full && (sum == i_byte);

    assign o_frame.id     = r_win[0];
    assign o_frame.cmd    = r_win[1];
    assign o_frame.sector = {r_win[3], r_win[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_step) begin
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end else if (o_match) begin
                r_fill <= '0;
            end
        end
    end

    // window contents carry no reset, only entries below the fill are read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (!full) begin
                r_win[r_fill[cfsd_pkg::WIN_IDX_W-1:0]] <= i_byte;
            end else if (!o_match) begin
                for (int k = 0; k < cfsd_pkg::WINDOW_DEPTH - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[cfsd_pkg::WINDOW_DEPTH-1] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/cfsd_decode.sv -----
// frame decode: device, unit, response action, length and drive status
`default_nettype none

module cfsd_decode (
    input  cfsd_pkg::t_frame  i_frame,
    input  cfsd_pkg::t_masks  i_masks,
    output cfsd_pkg::t_result o_result
);

    cfsd_pkg::t_kind             kind;
    logic [cfsd_pkg::BYTE_W-1:0] unit_off;
    logic [cfsd_pkg::UNIT_W-1:0] unit;
    logic                        present;
    logic                        ro;
    logic                        large_sec;
    logic                        enh;
    logic [cfsd_pkg::LEN_W-1:0]  xfer;
    logic [cfsd_pkg::BYTE_W-1:0] stat;
    logic [cfsd_pkg::BYTE_W-1:0] scs;
    cfsd_pkg::t_action           action;
    logic [cfsd_pkg::LEN_W-1:0]  len;

    always_comb begin
        kind     = cfsd_pkg::KIND_UNKNOWN;
        unit_off = '0;
        if (i_frame.id >= cfsd_pkg::ID_DISK_FIRST && i_frame.id <= cfsd_pkg::ID_DISK_LAST) begin
            kind     = cfsd_pkg::KIND_DISK;
            unit_off = i_frame.id - cfsd_pkg::ID_DISK_FIRST;
        end else if (i_frame.id >= cfsd_pkg::ID_PRN_FIRST &&
                     i_frame.id <= cfsd_pkg::ID_PRN_LAST) begin
            kind = cfsd_pkg::KIND_PRINTER;
            // first two printer ids share unit zero
            unit_off = (i_frame.id == cfsd_pkg::ID_PRN_FIRST) ? '0
                                                               : i_frame.id - cfsd_pkg::ID_PRN_UNIT0;
        end else if (i_frame.id >= cfsd_pkg::ID_SER_FIRST &&
                     i_frame.id <= cfsd_pkg::ID_SER_LAST) begin
            kind     = cfsd_pkg::KIND_SERIAL;
            unit_off = i_frame.id - cfsd_pkg::ID_SER_FIRST;
        end
    end

    assign unit = unit_off[cfsd_pkg::UNIT_W-1:0];

    // masks arrive zero extended, so units past the drive count read absent
    assign present   = i_masks.present[unit];
    assign ro        = i_masks.readonly[unit];
    assign large_sec = i_masks.large_sec[unit];
    assign enh       = i_masks.enhanced[unit];

    assign xfer = (i_frame.sector <= cfsd_pkg::SEC_BOOT_LAST) ? cfsd_pkg::LEN_SMALL
                : (large_sec ? cfsd_pkg::LEN_LARGE : cfsd_pkg::LEN_SMALL);

    always_comb begin
        action = cfsd_pkg::ACT_IGNORED;
        len    = '0;
        stat   = '0;
        scs    = '0;
        case (kind)
            cfsd_pkg::KIND_UNKNOWN: begin
                action = cfsd_pkg::ACT_IGNORED;
            end
            cfsd_pkg::KIND_DISK: begin
                if (!present) begin
                    action = cfsd_pkg::ACT_NO_IMAGE;
                end else begin
                    stat = large_sec ? cfsd_pkg::STAT_LARGE
                         : (enh ? cfsd_pkg::STAT_ENH : cfsd_pkg::STAT_SINGLE);
                    if (ro) begin
                        stat = stat | cfsd_pkg::STAT_RO_BIT;
                    end
                    // status frame is {stat, 0, 1, 0}
                    scs = cfsd_pkg::fold_add(cfsd_pkg::fold_add(cfsd_pkg::fold_add(
                              cfsd_pkg::fold_add('0, stat), 8'h00), 8'h01), 8'h00);
                    if (i_frame.cmd == cfsd_pkg::CMD_READ) begin
                        action = cfsd_pkg::ACT_READ;
                        len    = xfer;
                    end else if (i_frame.cmd == cfsd_pkg::CMD_WRITE ||
                                 i_frame.cmd == cfsd_pkg::CMD_PUT) begin
                        if (ro) begin
                            action = cfsd_pkg::ACT_WRITE_REFUSE;
                        end else begin
                            action = cfsd_pkg::ACT_WRITE_OK;
                            len    = xfer;
                        end
                    end else if (i_frame.cmd == cfsd_pkg::CMD_STATUS) begin
                        action = cfsd_pkg::ACT_STATUS;
                        len    = cfsd_pkg::LEN_STATUS;
                    end else begin
                        action = cfsd_pkg::ACT_NO_REPLY;
                    end
                end
            end
            default: begin
                action = cfsd_pkg::ACT_UNSUPPORTED;
            end
        endcase
    end

    assign o_result.device_kind     = kind;
    assign o_result.unit            = (kind == cfsd_pkg::KIND_UNKNOWN) ? '0 : unit;
    assign o_result.command_code    = i_frame.cmd;
    assign o_result.sector          = i_frame.sector;
    assign o_result.action          = action;
    assign o_result.data_length     = len;
    assign o_result.status_byte     = stat;
    assign o_result.status_checksum = scs;

endmodule

`default_nettype wire

// ----- src/command_frame_sync_and_decode.sv -----
// top level: command frame synchronizer and decoder with drive mask registers
//
// Bus bytes arrive on i_byte, one transfer per cycle at full rate unless a waiting
// result holds the flow. The block keeps the last four bytes and, once four are held,
// checks each new byte against their end-around-carry checksum; on a match the five
// bytes are a command frame, the window empties and one decoded result is offered on
// o_result, otherwise the oldest byte drops out and nothing is produced. Each byte is
// captured in an input register, the window update, checksum compare and frame decode
// run in a single pass of logic, and a result lands in the output register, so
// o_result.valid rises once the byte that closes its frame has passed both registers.
// The input register keeps taking a byte while a result waits; a further byte waits
// only when both the input and the output register are full. The four drive masks
// (present, read-only, 256-byte sectors, enhanced density) are written through i_cfg,
// always ready, and must only change while no byte is in flight. DRIVE_COUNT sets how
// many drive units exist; disk units beyond it report no image.
`default_nettype none

module command_frame_sync_and_decode #(
    parameter int DRIVE_COUNT = cfsd_pkg::DRIVE_COUNT_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cfsd_byte_if.sink      i_byte,
    cfsd_cfg_if.sink       i_cfg,
    cfsd_result_if.source  o_result
);

    // drive mask registers, one bit per existing unit
    logic [DRIVE_COUNT-1:0] r_present;
    logic [DRIVE_COUNT-1:0] r_readonly;
    logic [DRIVE_COUNT-1:0] r_large;
    logic [DRIVE_COUNT-1:0] r_enhanced;

    // input register
    logic                        r_in_valid;
    logic [cfsd_pkg::BYTE_W-1:0] r_in_byte;

    // output register
    logic              r_out_valid;
    cfsd_pkg::t_result r_out;

    logic              step;
    logic              match;
    cfsd_pkg::t_frame  frame;
    cfsd_pkg::t_masks  masks;
    cfsd_pkg::t_result decoded;

    // configuration writes are taken at once
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_readonly <= '0;
            r_large    <= '0;
            r_enhanced <= '0;
        end else if (i_cfg.valid) begin
            case (cfsd_pkg::t_reg_index'(i_cfg.reg_index))
                cfsd_pkg::REG_PRESENT:  r_present  <= i_cfg.wdata[DRIVE_COUNT-1:0];
                cfsd_pkg::REG_READONLY: r_readonly <= i_cfg.wdata[DRIVE_COUNT-1:0];
                cfsd_pkg::REG_LARGE:    r_large    <= i_cfg.wdata[DRIVE_COUNT-1:0];
                cfsd_pkg::REG_ENHANCED: r_enhanced <= i_cfg.wdata[DRIVE_COUNT-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero extend to the full unit range
    assign masks.present   = cfsd_pkg::t_mask'(r_present);
    assign masks.readonly  = cfsd_pkg::t_mask'(r_readonly);
    assign masks.large_sec = cfsd_pkg::t_mask'(r_large);
    assign masks.enhanced  = cfsd_pkg::t_mask'(r_enhanced);

    // the held byte moves on whenever the output register can take a result
    assign step         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.bus_byte;
        end
    end

    cfsd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_match (match),
        .o_frame (frame)
    );

    cfsd_decode u_decode (
        .i_frame  (frame),
        .i_masks  (masks),
        .o_result (decoded)
    );

    // result register: loaded on a frame match, freed by the sink's transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && match) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && match) begin
            r_out <= decoded;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.device_kind     = r_out.device_kind;
    assign o_result.unit            = r_out.unit;
    assign o_result.command_code    = r_out.command_code;
    assign o_result.sector          = r_out.sector;
    assign o_result.action          = r_out.action;
    assign o_result.data_length     = r_out.data_length;
    assign o_result.status_byte     = r_out.status_byte;
    assign o_result.status_checksum = r_out.status_checksum;

endmodule

`default_nettype wire

// ----- src/cfsd_checker.sv -----
// port-level checks of the command frame decoder, bound to the top level
`default_nettype none

module cfsd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_device_kind,
    input wire logic [2:0] i_unit,
    input wire logic [2:0] i_action,
    input wire logic [8:0] i_data_length,
    input wire logic [7:0] i_status_byte,
    input wire logic [7:0] i_status_checksum
);

    // a stalled result holds its action, device kind, unit and status byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_action) &&
        $stable(i_device_kind) && $stable(i_unit) && $stable(i_status_byte))
        else $error("stalled result changed");

    // unknown ids are ignored at unit zero
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_device_kind == cfsd_pkg::KIND_UNKNOWN |->
        i_action == cfsd_pkg::ACT_IGNORED && i_unit == 3'd0)
        else $error("unknown device not ignored");

    // no drive status or length without a present disk
    a_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == cfsd_pkg::ACT_IGNORED ||
                        i_action == cfsd_pkg::ACT_NO_IMAGE ||
                        i_action == cfsd_pkg::ACT_UNSUPPORTED) |->
        i_status_byte == 8'h00 && i_status_checksum == 8'h00 && i_data_length == 9'd0)
        else $error("status reported for absent drive");

    // status frame checksum follows the status byte
    a_status_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status_byte != 8'h00 |->
        i_status_checksum == i_status_byte + 8'h01 &&
        i_device_kind == cfsd_pkg::KIND_DISK)
        else $error("status checksum mismatch");

endmodule

bind command_frame_sync_and_decode cfsd_checker u_cfsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_device_kind     (o_result.device_kind),
    .i_unit            (o_result.unit),
    .i_action          (o_result.action),
    .i_data_length     (o_result.data_length),
    .i_status_byte     (o_result.status_byte),
    .i_status_checksum (o_result.status_checksum)
);

`default_nettype wire

// ----- tb/tb_command_frame_sync_and_decode.sv -----
`timescale 1ns / 100ps
// testbench: bus byte streams with framed commands, decoded results checked against a predictor

module tb_command_frame_sync_and_decode;

    localparam int DRIVES         = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;   // input and output register plus margin
    localparam int HOLDOFF_CYCLES = 80;
    localparam int MAX_PRINTS     = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cfsd_byte_if   byte_ch();
    cfsd_cfg_if    cfg_ch();
    cfsd_result_if res_ch();

    command_frame_sync_and_decode #(
        .DRIVE_COUNT(DRIVES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_result(res_ch)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: sliding byte window and the four drive masks
    // ------------------------------------------------------------------
    logic [7:0]  win_bytes [4];
    int unsigned win_count = 0;
    logic [7:0]  present_mask = '0;
    logic [7:0]  readonly_mask = '0;
    logic [7:0]  big_sector_mask = '0;
    logic [7:0]  enhanced_mask = '0;

    cfsd_pkg::t_result expected_frames [$];   // decoded frames still owed by the block
    logic [7:0]        bytes_to_send [$];     // bus bytes not yet offered

    int          errors = 0;
    int          cycles = 0;

    // idling controls shared between stimulus, driver and monitor
    bit          sender_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          holdoffs_asked = 0;
    int          holdoffs_done  = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 8-bit sum with end-around carry: a carry out counts as +1 in bit 0
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[8])
            s = s - 9'd255;
        return s[7:0];
    endfunction

    function automatic cfsd_pkg::t_result decode_frame(input logic [7:0] id,
                                                       input logic [7:0] cmd,
                                                       input logic [7:0] lo,
                                                       input logic [7:0] hi);
        cfsd_pkg::t_result r;
        int         unit_num;
        logic       ro;
        logic       big;
        logic       enh;
        logic [8:0] xfer;
        logic [7:0] st;

        r = '0;
        unit_num = 0;
        r.command_code = cmd;
        r.sector = {hi, lo};

        // device kind from the id byte
        if (id >= cfsd_pkg::ID_DISK_FIRST && id <= cfsd_pkg::ID_DISK_LAST) begin
            r.device_kind = cfsd_pkg::KIND_DISK;
            unit_num = id - cfsd_pkg::ID_DISK_FIRST;
        end else if (id >= cfsd_pkg::ID_PRN_FIRST && id <= cfsd_pkg::ID_PRN_LAST) begin
            r.device_kind = cfsd_pkg::KIND_PRINTER;
            // both the first and second printer ids map to unit 0
            unit_num = (id == cfsd_pkg::ID_PRN_FIRST) ? 0 : id - cfsd_pkg::ID_PRN_UNIT0;
        end else if (id >= cfsd_pkg::ID_SER_FIRST && id <= cfsd_pkg::ID_SER_LAST) begin
            r.device_kind = cfsd_pkg::KIND_SERIAL;
            unit_num = id - cfsd_pkg::ID_SER_FIRST;
        end else begin
            r.device_kind = cfsd_pkg::KIND_UNKNOWN;
        end
        r.unit = unit_num[2:0];

        if (r.device_kind == cfsd_pkg::KIND_UNKNOWN) begin
            r.action = cfsd_pkg::ACT_IGNORED;
        end else if (r.device_kind != cfsd_pkg::KIND_DISK) begin
            r.action = cfsd_pkg::ACT_UNSUPPORTED;
        end else if (unit_num >= DRIVES || !present_mask[unit_num]) begin
            // units past the drive count look like empty drives
            r.action = cfsd_pkg::ACT_NO_IMAGE;
        end else begin
            ro  = readonly_mask[unit_num];
            big = big_sector_mask[unit_num];
            enh = enhanced_mask[unit_num];
            // boot sectors are always 128 bytes
            if (r.sector <= cfsd_pkg::SEC_BOOT_LAST)
                xfer = cfsd_pkg::LEN_SMALL;
            else
                xfer = big ? cfsd_pkg::LEN_LARGE : cfsd_pkg::LEN_SMALL;

            st = big ? cfsd_pkg::STAT_LARGE
               : (enh ? cfsd_pkg::STAT_ENH : cfsd_pkg::STAT_SINGLE);
            if (ro)
                st = st | cfsd_pkg::STAT_RO_BIT;
            r.status_byte = st;
            // status frame is {status, 0, 1, 0}
            r.status_checksum = eac_add(eac_add(eac_add(st, 8'h00), 8'h01), 8'h00);

            if (cmd == cfsd_pkg::CMD_READ) begin
                r.action = cfsd_pkg::ACT_READ;
                r.data_length = xfer;
            end else if (cmd == cfsd_pkg::CMD_WRITE || cmd == cfsd_pkg::CMD_PUT) begin
                if (ro) begin
                    r.action = cfsd_pkg::ACT_WRITE_REFUSE;
                end else begin
                    r.action = cfsd_pkg::ACT_WRITE_OK;
                    r.data_length = xfer;
                end
            end else if (cmd == cfsd_pkg::CMD_STATUS) begin
                r.action = cfsd_pkg::ACT_STATUS;
                r.data_length = cfsd_pkg::LEN_STATUS;
            end else begin
                r.action = cfsd_pkg::ACT_NO_REPLY;
            end
        end
        return r;
    endfunction

    // one accepted bus byte: fill, then either match a frame or slide the window
    task automatic take_bus_byte(input logic [7:0] b);
        logic [7:0] sum;
        if (win_count < 4) begin
            win_bytes[win_count] = b;
            win_count++;
        end else begin
            sum = '0;
            for (int i = 0; i < 4; i++)
                sum = eac_add(sum, win_bytes[i]);
            if (sum == b) begin
                expected_frames.push_back(
                    decode_frame(win_bytes[0], win_bytes[1], win_bytes[2], win_bytes[3]));
                win_count = 0;
            end else begin
                win_bytes[0] = win_bytes[1];
                win_bytes[1] = win_bytes[2];
                win_bytes[2] = win_bytes[3];
                win_bytes[3] = b;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // byte driver: offers queued bytes, with random gaps of idle cycles
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid    <= 1'b0;
            byte_ch.bus_byte <= '0;
            gap_left = 0;
        end else begin
            // transfer at this edge goes to the predictor
            if (byte_ch.valid && byte_ch.ready)
                take_bus_byte(byte_ch.bus_byte);

            if (byte_ch.valid && !byte_ch.ready) begin
                // offer stays up until the block takes it
            end else if (gap_left > 0) begin
                byte_ch.valid <= 1'b0;
                gap_left--;
            end else if (sender_gaps_on && $urandom_range(0, 9) == 0) begin
                byte_ch.valid <= 1'b0;
                gap_left = $urandom_range(0, 5);
            end else if (bytes_to_send.size() > 0) begin
                byte_ch.valid    <= 1'b1;
                byte_ch.bus_byte <= bytes_to_send.pop_front();
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each transfer, stalls at random, long hold-off on request
    // ------------------------------------------------------------------
    int stall_left   = 0;
    int holdoff_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_PRINTS)
            $display("%0t result check failed on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_result;
        cfsd_pkg::t_result want;
        if (expected_frames.size() == 0) begin
            report_mismatch("unexpected result", res_ch.command_code, 0);
            return;
        end
        want = expected_frames.pop_front();
        if (res_ch.device_kind !== want.device_kind)
            report_mismatch("device_kind", res_ch.device_kind, want.device_kind);
        if (res_ch.unit !== want.unit)
            report_mismatch("unit", res_ch.unit, want.unit);
        if (res_ch.command_code !== want.command_code)
            report_mismatch("command_code", res_ch.command_code, want.command_code);
        if (res_ch.sector !== want.sector)
            report_mismatch("sector", res_ch.sector, want.sector);
        if (res_ch.action !== want.action)
            report_mismatch("action", res_ch.action, want.action);
        if (res_ch.data_length !== want.data_length)
            report_mismatch("data_length", res_ch.data_length, want.data_length);
        if (res_ch.status_byte !== want.status_byte)
            report_mismatch("status_byte", res_ch.status_byte, want.status_byte);
        if (res_ch.status_checksum !== want.status_checksum)
            report_mismatch("status_checksum", res_ch.status_checksum, want.status_checksum);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            holdoff_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                check_result();

            // a requested hold-off is counted here, independent of the sender
            if (holdoffs_done < holdoffs_asked) begin
                holdoffs_done++;
                holdoff_left = HOLDOFF_CYCLES;
            end

            if (holdoff_left > 0) begin
                res_ch.ready <= 1'b0;
                holdoff_left--;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("command_frame_sync_and_decode: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue a command frame; keep < 5 truncates it, corrupt flips one checksum bit
    task automatic queue_frame(input logic [7:0] id, input logic [7:0] cmd,
                               input logic [15:0] sec, input int keep, input bit corrupt);
        logic [7:0] frame_bytes [5];
        frame_bytes[0] = id;
        frame_bytes[1] = cmd;
        frame_bytes[2] = sec[7:0];
        frame_bytes[3] = sec[15:8];
        frame_bytes[4] = eac_add(eac_add(eac_add(id, cmd), sec[7:0]), sec[15:8]);
        if (corrupt)
            frame_bytes[4] = frame_bytes[4] ^ (8'h01 << $urandom_range(0, 7));
        for (int i = 0; i < keep; i++)
            bytes_to_send.push_back(frame_bytes[i]);
    endtask

    function automatic logic [7:0] pick_id();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return cfsd_pkg::ID_DISK_FIRST + 8'($urandom_range(0, 7));
        else if (pick == 6)
            return cfsd_pkg::ID_PRN_FIRST + 8'($urandom_range(0, 8));
        else if (pick == 7)
            return cfsd_pkg::ID_SER_FIRST + 8'($urandom_range(0, 3));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_cmd();
        case ($urandom_range(0, 5))
            0:       return cfsd_pkg::CMD_READ;
            1:       return cfsd_pkg::CMD_WRITE;
            2:       return cfsd_pkg::CMD_PUT;
            3:       return cfsd_pkg::CMD_STATUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sector values around the boot-sector boundary are favored
    function automatic logic [15:0] pick_sector();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 3));
            1:       return cfsd_pkg::SEC_BOOT_LAST;
            2:       return cfsd_pkg::SEC_BOOT_LAST + 16'd1;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly well-formed frames (only those when only_good is set); the rest broken checksums, cut-off frames and noise
    task automatic queue_random_traffic(input int n_bytes, input bit only_good);
        int added;
        int pick;
        int cut;
        added = 0;
        while (added < n_bytes) begin
            pick = only_good ? 0 : $urandom_range(0, 99);
            if (pick < 75) begin
                queue_frame(pick_id(), pick_cmd(), pick_sector(), 5, 1'b0);
                added += 5;
            end else if (pick < 85) begin
                queue_frame(pick_id(), pick_cmd(), pick_sector(), 5, 1'b1);
                added += 5;
            end else if (pick < 93) begin
                cut = $urandom_range(1, 4);
                queue_frame(pick_id(), pick_cmd(), pick_sector(), cut, 1'b0);
                added += cut;
            end else begin
                cut = $urandom_range(1, 3);
                repeat (cut)
                    bytes_to_send.push_back(8'($urandom_range(0, 255)));
                added += cut;
            end
        end
    endtask

    // register writes back to back; the block is idle whenever this runs
    task automatic program_masks(input logic [7:0] p, input logic [7:0] ro,
                                 input logic [7:0] big, input logic [7:0] enh);
        cfsd_pkg::t_reg_index regs [4] = '{cfsd_pkg::REG_PRESENT, cfsd_pkg::REG_READONLY,
                                           cfsd_pkg::REG_LARGE, cfsd_pkg::REG_ENHANCED};
        logic [7:0] vals [4];
        vals[0] = p;
        vals[1] = ro;
        vals[2] = big;
        vals[3] = enh;
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= regs[i];
            cfg_ch.wdata     <= vals[i];
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        present_mask    = p;
        readonly_mask   = ro;
        big_sector_mask = big;
        enhanced_mask   = enh;
    endtask

    // sender pause: everything sent, every frame back, then let the pipeline empty
    task automatic wait_until_idle;
        while (bytes_to_send.size() != 0 || byte_ch.valid || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
        while (byte_ch.valid || expected_frames.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_mask();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        byte_ch.valid    = 1'b0;
        byte_ch.bus_byte = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = cfsd_pkg::REG_PRESENT;
        cfg_ch.wdata     = '0;
        res_ch.ready     = 1'b0;

        repeat (2)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit 7 write protected, unit 0 large sectors, unit 1 enhanced
        program_masks(8'hFF, 8'h80, 8'h01, 8'h02);
        // stray byte first so the window has to slide before the frame lines up
        bytes_to_send.push_back(8'h00);
        queue_frame(cfsd_pkg::ID_DISK_FIRST, cfsd_pkg::CMD_READ, 16'h0000, 5, 1'b0);
        queue_frame(cfsd_pkg::ID_DISK_LAST, cfsd_pkg::CMD_PUT, 16'hFFFF, 5, 1'b0);
        queue_frame(cfsd_pkg::ID_DISK_FIRST + 8'd1, cfsd_pkg::CMD_STATUS, 16'h0004, 5, 1'b0);
        queue_frame(cfsd_pkg::ID_PRN_FIRST, cfsd_pkg::CMD_READ, 16'h0001, 5, 1'b0);
        queue_frame(8'hFF, 8'h00, 16'h0000, 5, 1'b0);
        wait_until_idle();

        // no drives present at all
        program_masks(8'h00, 8'h00, 8'h00, 8'h00);
        queue_random_traffic(100, 1'b0);
        wait_until_idle();

        // every mask bit set: large sectors win over enhanced, all write protected
        program_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_random_traffic(100, 1'b0);
        wait_until_idle();

        // back-pressure: sink holds off while the sender streams frames without gaps
        program_masks(8'hFF, rand_mask(), rand_mask(), rand_mask());
        sender_gaps_on = 1'b0;
        holdoffs_asked++;
        queue_random_traffic(100, 1'b1);
        wait_until_idle();
        sender_gaps_on = 1'b1;

        // alternating patterns across units
        program_masks(8'hAA, 8'h55, 8'h0F, 8'hF0);
        queue_random_traffic(120, 1'b0);
        wait_until_idle();

        program_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
        queue_random_traffic(100, 1'b0);
        wait_until_idle();

        program_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
        queue_random_traffic(100, 1'b0);
        wait_until_idle();

        // last stretch at full rate on both sides
        program_masks(rand_mask(), rand_mask(), rand_mask(), rand_mask());
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        queue_random_traffic(100, 1'b0);
        wait_until_idle();

        if (expected_frames.size() != 0)
            report_mismatch("missing result", expected_frames.size(), 0);

        if (errors == 0)
            $display("command_frame_sync_and_decode: match");
        else
            $display("command_frame_sync_and_decode: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
src/cfsd_pkg.sv
src/cfsd_if.sv
src/cfsd_window.sv
src/cfsd_decode.sv
src/command_frame_sync_and_decode.sv
src/cfsd_checker.sv
tb/tb_command_frame_sync_and_decode.sv
